// ===== hdl/crm_pkg.sv =====
// crm_pkg: shared constants, types and helper functions of the combined
// rotate-multiply generator; used by every module under hdl
package crm_pkg;

    localparam int unsigned WordW = 32;
    localparam int unsigned CntW  = 5;

    localparam logic [WordW-1:0] MulX   = 32'd2911329625;
    localparam logic [WordW-1:0] MulY   = 32'd4031235431;
    localparam logic [WordW-1:0] SubZ   = 32'd3286325185;
    localparam logic [WordW-1:0] SeedOfsX = 32'd4027999010;
    localparam logic [WordW-1:0] SeedOfsY = 32'd3993266363;
    localparam logic [WordW-1:0] SeedOfsZ = 32'd3605298456;
    localparam logic [CntW-1:0]  LastBit  = 5'd31;

    typedef enum logic [1:0] {
        CMD_SEED  = 2'd0,
        CMD_RAW   = 2'd1,
        CMD_RANGE = 2'd2,
        CMD_SPAN  = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_STEP,
        ST_DIV,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic             start;
        logic             load;
        logic [WordW-1:0] seed;
    } t_step_req;

    typedef struct packed {
        logic             start;
        logic [WordW-1:0] dividend;
        logic [WordW-1:0] divisor;
    } t_div_req;

    function automatic logic [WordW-1:0] rotl17(input logic [WordW-1:0] v);
        return {v[14:0], v[31:15]};
    endfunction

    function automatic logic [WordW-1:0] rotl15(input logic [WordW-1:0] v);
        return {v[16:0], v[31:17]};
    endfunction

    function automatic logic [WordW-1:0] rotl19(input logic [WordW-1:0] v);
        return {v[12:0], v[31:13]};
    endfunction

endpackage

// ===== hdl/crm_step.sv =====
// crm_step: generator state and bit-serial step, one multiplier bit per cycle
// depends on crm_pkg
module crm_step (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  crm_pkg::t_step_req    i_req,
    output logic                  o_done,
    output logic [31:0]           o_word
);
    import crm_pkg::*;

    logic [WordW-1:0] r_x, r_y, r_z;
    logic [WordW-1:0] r_sx, r_sy, r_ax, r_ay;
    logic [WordW-1:0] n_ax, n_ay;
    logic [CntW-1:0]  r_cnt;
    logic             r_busy;
    logic             r_done;

    // shift-add, multiplier msb first
    always_comb begin
        n_ax = {r_ax[WordW-2:0], 1'b0} + (r_sx[WordW-1] ? MulX : '0);
        n_ay = {r_ay[WordW-2:0], 1'b0} + (r_sy[WordW-1] ? MulY : '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x    <= SeedOfsX;
            r_y    <= SeedOfsY;
            r_z    <= SeedOfsZ;
            r_cnt  <= '0;
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.load) begin
                r_x <= {11'd0, i_req.seed[20:0]} + SeedOfsX;
                r_y <= {13'd0, i_req.seed[25:7]} + SeedOfsY;
                r_z <= {13'd0, i_req.seed[31:13]} + SeedOfsZ;
            end else if (i_req.start) begin
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == LastBit) begin
                    r_x    <= rotl17(~n_ax);
                    r_y    <= rotl15(n_ay);
                    r_z    <= SubZ - rotl19(r_z);
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_sx <= r_x;
            r_sy <= r_y;
            r_ax <= '0;
            r_ay <= '0;
        end else if (r_busy) begin
            r_sx <= {r_sx[WordW-2:0], 1'b0};
            r_sy <= {r_sy[WordW-2:0], 1'b0};
            r_ax <= n_ax;
            r_ay <= n_ay;
        end
    end

    assign o_done = r_done;
    assign o_word = (r_x + r_y) ^ r_z;

endmodule

// ===== hdl/crm_div.sv =====
// crm_div: radix-2 restoring remainder unit, one dividend bit per cycle
// depends on crm_pkg
module crm_div (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  crm_pkg::t_div_req     i_req,
    output logic                  o_done,
    output logic [31:0]           o_rem
);
    import crm_pkg::*;

    logic [WordW-1:0] r_q, r_rem, r_d;
    logic [WordW:0]   w_trial;
    logic [WordW:0]   w_diff;
    logic [WordW-1:0] n_rem;
    logic [CntW-1:0]  r_cnt;
    logic             r_busy;
    logic             r_done;

    always_comb begin
        w_trial = {r_rem, r_q[WordW-1]};
        w_diff  = w_trial - {1'b0, r_d};
        n_rem   = w_diff[WordW] ? w_trial[WordW-1:0] : w_diff[WordW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == LastBit) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_q   <= i_req.dividend;
            r_d   <= i_req.divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_q   <= {r_q[WordW-2:0], 1'b0};
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

// ===== hdl/combined_rotate_multiply_rng.sv =====
// combined_rotate_multiply_rng: top level, command sequencer and output register
// depends on crm_pkg, crm_step, crm_div
//
//  channel  | dir | tdata                                   | tuser
//  s_axis   | in  | seed[31:0] range[63:32] min[95:64] max[127:96] | command[1:0]
//  m_axis   | out | random_value[31:0]                      | -
//
// seed, zero range and empty bounds: no step, the sequencer goes from idle straight to done
// raw: the step unit runs its bit-serial multiply, then the sequencer goes to done
// range and min-max: step, then the remainder unit unless the span wraps to zero
// one item at a time; the next item is taken while a result waits in r_out
// synchronous active-low reset reloads the seed-zero state
module combined_rotate_multiply_rng (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    // seed_value, range_count, min_value, max_value
    input  logic [127:0]  s_axis_tdata,
    // command
    input  logic [1:0]    s_axis_tuser,
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    // random_value
    output logic [31:0]   m_axis_tdata
);
    import crm_pkg::*;

    t_state           r_state, n_state;
    t_step_req        w_step_req;
    t_div_req         w_div_req;
    t_cmd             w_cmd;
    logic             w_accept;
    logic             w_direct;
    logic [WordW-1:0] w_direct_res;
    logic [WordW-1:0] w_span;
    logic             w_step_done, w_div_done;
    logic [WordW-1:0] w_word, w_rem;
    logic             w_out_free;
    logic [WordW-1:0] w_seed, w_cnt, w_lo, w_hi;

    logic [WordW-1:0] r_mod, r_lo, r_res, r_out;
    logic             r_do_div;
    logic             r_m_valid;

    assign w_seed = s_axis_tdata[31:0];
    assign w_cnt  = s_axis_tdata[63:32];
    assign w_lo   = s_axis_tdata[95:64];
    assign w_hi   = s_axis_tdata[127:96];
    assign w_cmd  = t_cmd'(s_axis_tuser);
    assign w_span = w_hi - w_lo + 1'b1;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_out_free    = !r_m_valid || m_axis_tready;

    // commands that finish without stepping
    always_comb begin
        w_direct     = 1'b0;
        w_direct_res = '0;
        unique case (w_cmd)
            CMD_SEED:  w_direct = 1'b1;
            CMD_RAW:   w_direct = 1'b0;
            CMD_RANGE: w_direct = (w_cnt == '0);
            CMD_SPAN: begin
                w_direct     = (w_lo >= w_hi);
                w_direct_res = w_lo;
            end
            default:   w_direct = 1'b1;
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (w_accept) n_state = w_direct ? ST_DONE : ST_STEP;
            ST_STEP: if (w_step_done) n_state = r_do_div ? ST_DIV : ST_DONE;
            ST_DIV:  if (w_div_done) n_state = ST_DONE;
            ST_DONE: if (w_out_free) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        w_step_req.start    = 1'b0;
        w_step_req.load     = 1'b0;
        w_step_req.seed     = w_seed;
        w_div_req.start     = 1'b0;
        w_div_req.dividend  = w_word;
        w_div_req.divisor   = r_mod;
        unique case (r_state)
            ST_IDLE: begin
                w_step_req.load  = w_accept && (w_cmd == CMD_SEED);
                w_step_req.start = w_accept && !w_direct;
            end
            ST_STEP: w_div_req.start = w_step_done && r_do_div;
            ST_DIV:  ;
            ST_DONE: ;
            default: ;
        endcase
    end

    crm_step u_step (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_step_req),
        .o_done  (w_step_done),
        .o_word  (w_word)
    );

    crm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_done  (w_div_done),
        .o_rem   (w_rem)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_m_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_DONE && w_out_free) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_res <= w_direct_res;
            if (w_cmd == CMD_RANGE) begin
                r_mod    <= w_cnt;
                r_lo     <= '0;
                r_do_div <= 1'b1;
            end else if (w_cmd == CMD_SPAN) begin
                r_mod    <= w_span;
                r_lo     <= (w_span != '0) ? w_lo : '0;
                r_do_div <= (w_span != '0);
            end else begin
                r_mod    <= w_cnt;
                r_lo     <= '0;
                r_do_div <= 1'b0;
            end
        end else if (r_state == ST_STEP && w_step_done) begin
            r_res <= w_word;
        end else if (r_state == ST_DIV && w_div_done) begin
            r_res <= r_lo + w_rem;
        end
        if (r_state == ST_DONE && w_out_free) begin
            r_out <= r_res;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_out;

    a_step_done_in_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_step_done |-> r_state == ST_STEP)
        else $error("step finished outside step state");

    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> r_state == ST_DIV)
        else $error("remainder finished outside divide state");

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_state != ST_IDLE)
        else $error("accepted item left sequencer idle");

    a_done_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE && r_m_valid && !m_axis_tready) |=> r_state == ST_DONE)
        else $error("result dropped while output register full");

endmodule

// ===== sim/combined_rotate_multiply_rng_tb.sv =====
// testbench for combined_rotate_multiply_rng: drives seed, raw, range and min-max items
// and checks every result word against a local model of the three sub-generators
// depends on crm_pkg and the combined_rotate_multiply_rng rtl
module combined_rotate_multiply_rng_tb;
    import crm_pkg::*;

    logic          i_clk;
    logic          i_rst_n;
    logic          s_axis_tvalid;
    logic          s_axis_tready;
    // seed_value, range_count, min_value, max_value
    logic [127:0]  s_axis_tdata;
    // command
    logic [1:0]    s_axis_tuser;
    logic          m_axis_tvalid;
    logic          m_axis_tready;
    // random_value
    logic [31:0]   m_axis_tdata;

    logic [31:0]   model_x;
    logic [31:0]   model_y;
    logic [31:0]   model_z;
    logic [31:0]   exp_words[$];
    int unsigned   err_cnt;
    bit            idle_on;
    int unsigned   hold_tag;
    int unsigned   hold_len;

    combined_rotate_multiply_rng u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #8_000_000;
        $display("Regression FAIL");
        $finish;
    end

    function automatic logic [31:0] rot_left(input logic [31:0] v, input int unsigned n);
        return (v << n) | (v >> (32 - n));
    endfunction

    function void load_model_seed(input logic [31:0] s);
        model_x = (s & 32'h001f_ffff) + SeedOfsX;
        model_y = ((s >> 7) & 32'h0007_ffff) + SeedOfsY;
        model_z = (s >> 13) + SeedOfsZ;
    endfunction

    function logic [31:0] next_model_word();
        logic [31:0] prod;
        prod    = MulX * model_x;
        model_x = rot_left(~prod, 17);
        prod    = MulY * model_y;
        model_y = rot_left(prod, 15);
        model_z = SubZ - rot_left(model_z, 19);
        return (model_x + model_y) ^ model_z;
    endfunction

    function logic [31:0] predict_random_value(input t_cmd cmd, input logic [31:0] seed,
                                               input logic [31:0] cnt, input logic [31:0] lo,
                                               input logic [31:0] hi);
        logic [31:0] word;
        logic [31:0] span;
        word = '0;
        case (cmd)
            CMD_SEED: begin
                load_model_seed(seed);
            end
            CMD_RAW: begin
                word = next_model_word();
            end
            CMD_RANGE: begin
                if (cnt != 0) begin
                    word = next_model_word() % cnt;
                end
            end
            default: begin
                if (lo >= hi) begin
                    word = lo;
                end else begin
                    word = next_model_word();
                    span = hi - lo + 32'd1;
                    if (span != 0) begin
                        word = lo + word % span;
                    end
                end
            end
        endcase
        return word;
    endfunction

    function int unsigned pick_gap();
        int unsigned r;
        if (!idle_on) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end else if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    task automatic send_item(input t_cmd cmd, input logic [31:0] seed, input logic [31:0] cnt,
                             input logic [31:0] lo, input logic [31:0] hi);
        int unsigned gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tdata  <= {hi, lo, cnt, seed};
        s_axis_tuser  <= cmd;
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        exp_words.push_back(predict_random_value(cmd, seed, cnt, lo, hi));
    endtask

    task automatic send_random_item();
        t_cmd        cmd;
        logic [31:0] seed;
        logic [31:0] cnt;
        logic [31:0] lo;
        logic [31:0] hi;
        int unsigned r;
        seed = $urandom;
        cnt  = $urandom;
        lo   = $urandom;
        hi   = $urandom;
        r    = $urandom_range(0, 99);
        if (r < 8) begin
            cmd = CMD_SEED;
        end else if (r < 38) begin
            cmd = CMD_RAW;
        end else if (r < 69) begin
            cmd = CMD_RANGE;
        end else begin
            cmd = CMD_SPAN;
        end
        r = $urandom_range(0, 99);
        if (cmd == CMD_RANGE) begin
            if (r < 10) begin
                cnt = '0;
            end else if (r < 50) begin
                cnt = $urandom_range(1, 1000);
            end else if (r < 65) begin
                cnt = 32'd1 << $urandom_range(0, 31);
            end
        end else if (cmd == CMD_SPAN) begin
            if (r < 10) begin
                hi = lo - $urandom_range(0, 3);
            end else if (r < 18) begin
                lo = '0;
                hi = '1;
            end else if (r < 55) begin
                lo = $urandom_range(0, 32'hffff_0000);
                hi = lo + $urandom_range(1, 5000);
            end else if (lo > hi) begin
                {lo, hi} = {hi, lo};
            end
        end
        send_item(cmd, seed, cnt, lo, hi);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (exp_words.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_reset_state();
        send_item(CMD_RAW, $urandom, $urandom, $urandom, $urandom);
        send_item(CMD_RAW, $urandom, $urandom, $urandom, $urandom);
    endtask

    task automatic test_seed_load();
        logic [31:0] seeds[6];
        seeds = '{32'h0000_0000, 32'hffff_ffff, 32'h8000_0000, 32'h5555_5555,
                  32'haaaa_aaaa, 32'h001f_ff80};
        foreach (seeds[i]) begin
            send_item(CMD_SEED, seeds[i], $urandom, $urandom, $urandom);
            if (i % 2 == 0) begin
                send_item(CMD_RAW, $urandom, $urandom, $urandom, $urandom);
            end
        end
    endtask

    task automatic test_range_reduce();
        send_item(CMD_RANGE, $urandom, 32'd0, $urandom, $urandom);
        send_item(CMD_RANGE, $urandom, 32'd1, $urandom, $urandom);
        send_item(CMD_RANGE, $urandom, 32'hffff_ffff, $urandom, $urandom);
        send_item(CMD_RANGE, $urandom, 32'h8000_0000, $urandom, $urandom);
        send_item(CMD_RANGE, $urandom, 32'd7, $urandom, $urandom);
    endtask

    task automatic test_min_max();
        send_item(CMD_SPAN, $urandom, $urandom, 32'd100, 32'd20);
        send_item(CMD_SPAN, $urandom, $urandom, 32'hffff_ffff, 32'hffff_ffff);
        send_item(CMD_SPAN, $urandom, $urandom, 32'd0, 32'hffff_ffff);
        send_item(CMD_SPAN, $urandom, $urandom, 32'd0, 32'd1);
        send_item(CMD_SPAN, $urandom, $urandom, 32'hffff_fffe, 32'hffff_ffff);
        send_item(CMD_SPAN, $urandom, $urandom, 32'd5, 32'd10);
        send_item(CMD_SPAN, $urandom, $urandom, 32'd1, 32'hffff_ffff);
    endtask

    task automatic test_random_traffic(input int unsigned n_items);
        repeat (n_items) send_random_item();
    endtask

    task automatic test_output_backpressure();
        hold_len = 300;
        hold_tag = hold_tag + 1;
        repeat (20) send_random_item();
    endtask

    task automatic test_drain_pause();
        repeat (5) begin
            repeat (8) send_random_item();
            wait_drained();
            repeat ($urandom_range(1, 20)) @(posedge i_clk);
        end
    endtask

    task automatic test_back_to_back();
        idle_on = 1'b0;
        repeat (80) send_random_item();
        idle_on = 1'b1;
    endtask

    // output side: random stalls, plus one long hold-off on request
    initial begin
        int unsigned stall_left;
        int unsigned seen_tag;
        int unsigned r;
        logic        rdy;
        stall_left = 0;
        seen_tag   = 0;
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_tag != seen_tag) begin
                seen_tag   = hold_tag;
                stall_left = hold_len;
            end
            if (stall_left > 0) begin
                stall_left = stall_left - 1;
                rdy = 1'b0;
            end else if (!idle_on) begin
                rdy = 1'b1;
            end else begin
                r = $urandom_range(0, 99);
                rdy = (r < 75);
                if (r >= 75 && r < 95) begin
                    stall_left = $urandom_range(0, 2);
                end else if (r >= 95) begin
                    stall_left = $urandom_range(10, 40);
                end
            end
            m_axis_tready <= rdy;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (exp_words.size() == 0) begin
                $error("random_value: unexpected item, actual %h", m_axis_tdata);
                err_cnt = err_cnt + 1;
            end else begin
                if (m_axis_tdata !== exp_words[0]) begin
                    $error("random_value mismatch: expected %h, actual %h",
                           exp_words[0], m_axis_tdata);
                    err_cnt = err_cnt + 1;
                end
                void'(exp_words.pop_front());
            end
        end
    end

    initial begin
        err_cnt  = 0;
        idle_on  = 1'b1;
        hold_tag = 0;
        hold_len = 0;
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= CMD_SEED;
        load_model_seed(32'd0);
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_state();
        test_seed_load();
        test_range_reduce();
        test_min_max();
        test_random_traffic(600);
        test_output_backpressure();
        test_drain_pause();
        test_back_to_back();
        test_random_traffic(560);

        wait_drained();
        repeat (100) @(posedge i_clk);
        if (err_cnt == 0 && exp_words.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
